// File: hw/rtl/cmt_pkg.sv
// Package for the counting multiset table: sizes, action codes and the
// command/status structs between controller and datapath. No dependencies.
package cmt_pkg;

	localparam int CAPACITY   = 256;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = 16;

	localparam int ACTION_W  = 2;
	localparam int IN_VALUE_W = 32;
	localparam int RESULT_W  = 16;
	localparam int DISTINCT_W = 9;
	localparam int TOTAL_W   = 24;

	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LIVE_W = $clog2(CAPACITY + 1);
	localparam int WORD_W = VALUE_BITS + COUNT_BITS;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT    = 2'd0,
		ACT_ERASE_ONE = 2'd1,
		ACT_ERASE_ALL = 2'd2,
		ACT_COUNT     = 2'd3
	} action_t;

	typedef struct packed {
		logic load;    // latch request, restart scan
		logic rd_en;   // read slot at scan address, advance
		logic commit;  // apply update, load result word
	} cmd_t;

	typedef struct packed {
		logic scan_end; // scan address is at the last slot
	} stat_t;

endpackage

// File: hw/rtl/cmt_req_if.sv
// Request channel of the counting multiset table: valid/ready plus fields.
// Depends on cmt_pkg.
interface cmt_req_if;
	import cmt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [IN_VALUE_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

// File: hw/rtl/cmt_rsp_if.sv
// Result channel of the counting multiset table: valid/ready plus fields.
// Depends on cmt_pkg.
interface cmt_rsp_if;
	import cmt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  status;
	logic [RESULT_W-1:0]   result_count;
	logic [DISTINCT_W-1:0] distinct_entries;
	logic [TOTAL_W-1:0]    total_items;

	modport source (output valid, output status, output result_count,
		output distinct_entries, output total_items, input ready);
	modport sink   (input valid, input status, input result_count,
		input distinct_entries, input total_items, output ready);
endinterface

// File: hw/rtl/cmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: hw/rtl/cmt_datapath.sv
// Datapath of the counting multiset table: slot RAM, live bits, scan
// registers, update logic and result register. Depends on cmt_pkg, cmt_ram.
module cmt_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cmt_pkg::cmd_t                  cmd,
	output cmt_pkg::stat_t                 stat,
	input  logic [cmt_pkg::ACTION_W-1:0]   in_action,
	input  logic [cmt_pkg::IN_VALUE_W-1:0] in_value,
	output logic                           out_status,
	output logic [cmt_pkg::RESULT_W-1:0]   out_result_count,
	output logic [cmt_pkg::DISTINCT_W-1:0] out_distinct_entries,
	output logic [cmt_pkg::TOTAL_W-1:0]    out_total_items
);
	import cmt_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// request and scan registers
	logic [ACTION_W-1:0]   act_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [IDX_W-1:0]      addr_q;
	logic [IDX_W-1:0]      idx_s1;
	logic                  rd_valid_s1;
	logic                  found_q;
	logic                  have_free_q;
	logic [IDX_W-1:0]      hit_q;
	logic [IDX_W-1:0]      free_q;
	logic [COUNT_BITS-1:0] cnt_q;

	// table state
	logic [CAPACITY-1:0]   live_q;
	logic [LIVE_W-1:0]     live_slots_q;
	logic [TOTAL_W-1:0]    total_q;

	logic [WORD_W-1:0]     rdata;
	logic [VALUE_BITS-1:0] rd_value;
	logic [COUNT_BITS-1:0] rd_count;
	logic                  rd_live;

	// commit controls
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [COUNT_BITS-1:0] wr_cnt;
	logic                  set_live;
	logic                  clr_live;
	logic                  live_inc;
	logic                  live_dec;
	logic [TOTAL_W-1:0]    total_next;
	logic                  ok;
	logic [COUNT_BITS-1:0] reply;

	cmt_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CAPACITY)
	) u_slots (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata ({val_q, wr_cnt}),
		.re    (cmd.rd_en),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign rd_value = rdata[WORD_W-1:COUNT_BITS];
	assign rd_count = rdata[COUNT_BITS-1:0];
	assign rd_live  = live_q[idx_s1];
	assign stat.scan_end = (addr_q == IDX_W'(CAPACITY - 1));

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = hit_q;
		wr_cnt     = cnt_q;
		set_live   = 1'b0;
		clr_live   = 1'b0;
		live_inc   = 1'b0;
		live_dec   = 1'b0;
		total_next = total_q;
		ok         = 1'b0;
		reply      = '0;
		unique case (action_t'(act_q))
			ACT_INSERT: begin
				if (found_q) begin
					reply = cnt_q;
					if (cnt_q != COUNT_MAX) begin
						wr_en      = 1'b1;
						wr_cnt     = cnt_q + 1'b1;
						reply      = cnt_q + 1'b1;
						total_next = total_q + 1'b1;
						ok         = 1'b1;
					end
				end else if (have_free_q) begin
					wr_en      = 1'b1;
					wr_addr    = free_q;
					wr_cnt     = COUNT_BITS'(1);
					set_live   = 1'b1;
					live_inc   = 1'b1;
					total_next = total_q + 1'b1;
					ok         = 1'b1;
					reply      = COUNT_BITS'(1);
				end
			end
			ACT_ERASE_ONE: begin
				if (found_q) begin
					wr_en      = 1'b1;
					wr_cnt     = cnt_q - 1'b1;
					total_next = total_q - 1'b1;
					ok         = 1'b1;
					reply      = COUNT_BITS'(1);
					if (cnt_q == COUNT_BITS'(1)) begin
						clr_live = 1'b1;
						live_dec = 1'b1;
					end
				end
			end
			ACT_ERASE_ALL: begin
				if (found_q) begin
					clr_live   = 1'b1;
					live_dec   = 1'b1;
					total_next = total_q - TOTAL_W'(cnt_q);
					ok         = 1'b1;
					reply      = cnt_q;
				end
			end
			ACT_COUNT: begin
				if (found_q) begin
					ok    = 1'b1;
					reply = cnt_q;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (!cmd.commit) begin
			wr_en = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1  <= 1'b0;
			found_q      <= 1'b0;
			have_free_q  <= 1'b0;
			live_q       <= '0;
			live_slots_q <= '0;
			total_q      <= '0;
			addr_q       <= '0;
		end else begin
			rd_valid_s1 <= cmd.rd_en;
			if (cmd.load) begin
				found_q     <= 1'b0;
				have_free_q <= 1'b0;
				addr_q      <= '0;
			end else if (cmd.rd_en && !stat.scan_end) begin
				addr_q <= addr_q + 1'b1;
			end
			// first live match wins, first dead slot is the free one
			if (rd_valid_s1) begin
				if (rd_live) begin
					if (!found_q && rd_value == val_q) begin
						found_q <= 1'b1;
					end
				end else if (!have_free_q) begin
					have_free_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				if (set_live) begin
					live_q[free_q] <= 1'b1;
				end
				if (clr_live) begin
					live_q[hit_q] <= 1'b0;
				end
				if (live_inc) begin
					live_slots_q <= live_slots_q + 1'b1;
				end else if (live_dec) begin
					live_slots_q <= live_slots_q - 1'b1;
				end
				total_q <= total_next;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			val_q <= VALUE_BITS'(in_value);
		end
		idx_s1 <= addr_q;
		if (rd_valid_s1) begin
			if (rd_live) begin
				if (!found_q && rd_value == val_q) begin
					hit_q <= idx_s1;
					cnt_q <= rd_count;
				end
			end else if (!have_free_q) begin
				free_q <= idx_s1;
			end
		end
		if (cmd.commit) begin
			out_status           <= ok;
			out_result_count     <= RESULT_W'(reply);
			out_distinct_entries <= DISTINCT_W'(live_inc ? live_slots_q + 1'b1 :
				live_dec ? live_slots_q - 1'b1 : live_slots_q);
			out_total_items      <= total_next;
		end
	end
endmodule

// File: hw/rtl/cmt_ctrl.sv
// Controller of the counting multiset table: sequences accept, scan,
// drain and commit, and owns the result valid flag. Depends on cmt_pkg.
module cmt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output cmt_pkg::cmd_t  cmd,
	input  cmt_pkg::stat_t stat
);
	import cmt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free    = !out_valid || out_ready;
	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.load    = in_ready && in_valid;
	assign cmd.rd_en   = (state_q == ST_SCAN);
	assign cmd.commit  = (state_q == ST_COMMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			// a new result word replaces the one taken at this edge
			if (cmd.commit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.scan_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					// hold until the previous result word is gone
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

// File: hw/rtl/counting_multiset_table.sv
// Top level of the counting multiset table: controller plus datapath.
// Depends on cmt_pkg, cmt_req_if, cmt_rsp_if, cmt_ctrl, cmt_datapath.
//
// A table of CAPACITY (value, count) slots used as a counting multiset.
// Each request word (action, value) inserts, erases one copy, erases all
// copies or queries the count, and yields exactly one result word with
// status, the reported count, the number of live slots and the total of
// all counts. From acceptance to the next possible acceptance a request
// goes through the accept step, a scan of the single-read slot RAM one
// slot per cycle, a drain step for the last read word and a commit
// step. The result sits in an output register, so the next request
// is accepted while it waits; commit stalls only if the previous
// result is still untaken. Live bits in flip-flops clear at reset, so
// no clearing pass is needed and requests are taken at once.
module counting_multiset_table (
	input  logic clk,
	input  logic arst_n,
	cmt_req_if.sink   req,
	cmt_rsp_if.source rsp
);
	import cmt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	cmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	cmt_datapath u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.in_action            (req.action),
		.in_value             (req.value),
		.out_status           (rsp.status),
		.out_result_count     (rsp.result_count),
		.out_distinct_entries (rsp.distinct_entries),
		.out_total_items      (rsp.total_items)
	);
endmodule

// File: tb/tb_counting_multiset_table.sv
`timescale 1ns / 100ps
// Testbench for counting_multiset_table: directed rows, then random request words under
// several idle and stall mixes, each result checked against its typed row or a mirror.
// Depends on cmt_pkg, cmt_req_if, cmt_rsp_if and the RTL of the block.
module tb_counting_multiset_table;
	import cmt_pkg::*;

	localparam int WATCHDOG_LIMIT = 8000;
	localparam int HOLD_OFF_CYCLES = 1500;
	localparam int POOL_SIZE = 8;
	localparam int DIRECTED_ROWS = 24;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic                  status;
		logic [RESULT_W-1:0]   result_count;
		logic [DISTINCT_W-1:0] distinct_entries;
		logic [TOTAL_W-1:0]    total_items;
	} reply_t;

	typedef struct packed {
		action_t               act;
		logic [IN_VALUE_W-1:0] value;
		logic                  typed;
		reply_t                want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	cmt_req_if req_ch();
	cmt_rsp_if rsp_ch();

	counting_multiset_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #5 clk = ~clk;

	// mirror of the slot table
	logic [VALUE_BITS-1:0] slot_value [CAPACITY];
	logic [COUNT_BITS-1:0] slot_count [CAPACITY];
	logic [LIVE_W-1:0]     live_slots;
	logic [TOTAL_W-1:0]    item_total;

	reply_t                awaited_replies [$];
	logic [IN_VALUE_W-1:0] value_pool [POOL_SIZE];
	int unsigned           mismatch_count = 0;
	int unsigned           send_idle_pct = 0;
	int unsigned           stall_pct = 0;
	int unsigned           hold_left = 0;
	int unsigned           quiet_cycles;

	// typed rows can be read straight off the behavior; the rest go through the mirror
	row_t directed [DIRECTED_ROWS] = '{
		'{ACT_COUNT,     32'h0000_0000, 1'b1, '{1'b0, 16'd0, 9'd0, 24'd0}},
		'{ACT_ERASE_ONE, 32'hFFFF_FFFF, 1'b1, '{1'b0, 16'd0, 9'd0, 24'd0}},
		'{ACT_ERASE_ALL, 32'h0000_0000, 1'b1, '{1'b0, 16'd0, 9'd0, 24'd0}},
		'{ACT_INSERT,    32'h0000_0000, 1'b1, '{1'b1, 16'd1, 9'd1, 24'd1}},
		'{ACT_INSERT,    32'h0000_0000, 1'b1, '{1'b1, 16'd2, 9'd1, 24'd2}},
		'{ACT_INSERT,    32'hFFFF_FFFF, 1'b1, '{1'b1, 16'd1, 9'd2, 24'd3}},
		'{ACT_COUNT,     32'h0000_0000, 1'b1, '{1'b1, 16'd2, 9'd2, 24'd3}},
		'{ACT_COUNT,     32'hFFFF_FFFF, 1'b1, '{1'b1, 16'd1, 9'd2, 24'd3}},
		'{ACT_COUNT,     32'hFFFF_FFFE, 1'b1, '{1'b0, 16'd0, 9'd2, 24'd3}},
		'{ACT_ERASE_ONE, 32'h0000_0000, 1'b1, '{1'b1, 16'd1, 9'd2, 24'd2}},
		'{ACT_ERASE_ALL, 32'hFFFF_FFFF, 1'b1, '{1'b1, 16'd1, 9'd1, 24'd1}},
		'{ACT_COUNT,     32'hFFFF_FFFF, 1'b1, '{1'b0, 16'd0, 9'd1, 24'd1}},
		'{ACT_ERASE_ONE, 32'h0000_0000, 1'b1, '{1'b1, 16'd1, 9'd0, 24'd0}},
		'{ACT_ERASE_ONE, 32'h0000_0000, 1'b1, '{1'b0, 16'd0, 9'd0, 24'd0}},
		'{ACT_INSERT,    32'h8000_0000, 1'b0, '0},
		'{ACT_INSERT,    32'h7FFF_FFFF, 1'b0, '0},
		'{ACT_INSERT,    32'h0000_0001, 1'b0, '0},
		'{ACT_INSERT,    32'h8000_0000, 1'b0, '0},
		'{ACT_ERASE_ALL, 32'h7FFF_FFFF, 1'b0, '0},
		'{ACT_INSERT,    32'hA5A5_A5A5, 1'b0, '0},
		'{ACT_ERASE_ONE, 32'h8000_0000, 1'b0, '0},
		'{ACT_COUNT,     32'h8000_0000, 1'b0, '0},
		'{ACT_ERASE_ALL, 32'h8000_0000, 1'b0, '0},
		'{ACT_COUNT,     32'hA5A5_A5A5, 1'b0, '0}
	};

	// Apply one request to the mirror and return the result word it should produce.
	function automatic reply_t mirror_request(action_t act, logic [IN_VALUE_W-1:0] value);
		logic [VALUE_BITS-1:0] key;
		bit found;
		bit have_free;
		int hit;
		int free_idx;
		int i;
		reply_t r;
		key = value[VALUE_BITS-1:0];
		found = 1'b0;
		have_free = 1'b0;
		hit = 0;
		free_idx = 0;
		r = '0;
		// only live slots take part in matching
		for (i = 0; i < CAPACITY; i++) begin
			if (slot_count[i] != 0) begin
				if (!found && slot_value[i] == key) begin
					found = 1'b1;
					hit = i;
				end
			end else if (!have_free) begin
				have_free = 1'b1;
				free_idx = i;
			end
		end
		case (act)
			ACT_INSERT: begin
				if (found) begin
					// saturated count: report it unchanged, leave the table alone
					if (slot_count[hit] != COUNT_MAX) begin
						slot_count[hit]++;
						item_total++;
						r.status = 1'b1;
					end
					r.result_count = RESULT_W'(slot_count[hit]);
				end else if (have_free) begin
					slot_value[free_idx] = key;
					slot_count[free_idx] = COUNT_BITS'(1);
					live_slots++;
					item_total++;
					r.status = 1'b1;
					r.result_count = RESULT_W'(1);
				end
			end
			ACT_ERASE_ONE: begin
				if (found) begin
					slot_count[hit]--;
					if (slot_count[hit] == 0)
						live_slots--;
					item_total--;
					r.status = 1'b1;
					r.result_count = RESULT_W'(1);
				end
			end
			ACT_ERASE_ALL: begin
				if (found) begin
					r.result_count = RESULT_W'(slot_count[hit]);
					item_total = item_total - TOTAL_W'(slot_count[hit]);
					slot_count[hit] = 0;
					live_slots--;
					r.status = 1'b1;
				end
			end
			default: begin
				if (found) begin
					r.result_count = RESULT_W'(slot_count[hit]);
					r.status = 1'b1;
				end
			end
		endcase
		r.distinct_entries = DISTINCT_W'(live_slots);
		r.total_items = item_total;
		return r;
	endfunction

	// Value of a random live slot, or a fresh random value if the table is empty.
	function automatic logic [IN_VALUE_W-1:0] live_value();
		int start;
		int k;
		int idx;
		start = $urandom_range(CAPACITY - 1);
		for (k = 0; k < CAPACITY; k++) begin
			idx = (start + k) % CAPACITY;
			if (slot_count[idx] != 0)
				return IN_VALUE_W'(slot_value[idx]);
		end
		return $urandom();
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Offer one request word; called and returning at a falling edge.
	task automatic put_request(input action_t act, input logic [IN_VALUE_W-1:0] value,
			input logic typed, input reply_t want);
		reply_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.value <= value;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		r = mirror_request(act, value);
		awaited_replies.push_back(typed ? want : r);
		@(negedge clk);
	endtask

	task automatic refresh_pool();
		int i;
		for (i = 0; i < POOL_SIZE; i++)
			value_pool[i] = $urandom();
	endtask

	// Mostly values that are or were recently in the table, so hits are common.
	task automatic run_mix(input int n);
		int i;
		int unsigned pick;
		action_t act;
		logic [IN_VALUE_W-1:0] v;
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				act = ACT_INSERT;
			else if (pick < 60)
				act = ACT_ERASE_ONE;
			else if (pick < 75)
				act = ACT_ERASE_ALL;
			else
				act = ACT_COUNT;
			pick = $urandom_range(99);
			if (pick < 55)
				v = value_pool[$urandom_range(POOL_SIZE - 1)];
			else if (pick < 80)
				v = live_value();
			else
				v = $urandom();
			put_request(act, v, 1'b0, '0);
		end
	endtask

	// Fill every slot, then work the full table: failed inserts, hits, frees and refills.
	task automatic fill_and_churn();
		int i;
		while (live_slots < CAPACITY)
			put_request(ACT_INSERT, $urandom(), 1'b0, '0);
		for (i = 0; i < 36; i++) begin
			case ($urandom_range(4))
				0: put_request(ACT_INSERT, $urandom(), 1'b0, '0);
				1: put_request(ACT_INSERT, live_value(), 1'b0, '0);
				2: put_request(ACT_COUNT, live_value(), 1'b0, '0);
				3: put_request(ACT_ERASE_ONE, live_value(), 1'b0, '0);
				default: begin
					put_request(ACT_ERASE_ALL, live_value(), 1'b0, '0);
					put_request(ACT_INSERT, $urandom(), 1'b0, '0);
				end
			endcase
		end
	endtask

	// result side: ready at the falling edge, with an optional long hold-off
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		reply_t w;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_replies.size() == 0) begin
				$display("%0t: result word with none expected: status %0h count %0h %s %0h %0h",
					$time, rsp_ch.status, rsp_ch.result_count, "distinct/total",
					rsp_ch.distinct_entries, rsp_ch.total_items);
				mismatch_count++;
			end else begin
				w = awaited_replies.pop_front();
				check_field("status", 32'(w.status), 32'(rsp_ch.status));
				check_field("result_count", 32'(w.result_count), 32'(rsp_ch.result_count));
				check_field("distinct_entries", 32'(w.distinct_entries),
					32'(rsp_ch.distinct_entries));
				check_field("total_items", 32'(w.total_items), 32'(rsp_ch.total_items));
			end
		end
	end

	// end the run if neither channel moves a word for too long
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("counting_multiset_table test failed");
		$finish;
	end

	initial begin
		int i;
		for (i = 0; i < CAPACITY; i++) begin
			slot_value[i] = '0;
			slot_count[i] = '0;
		end
		live_slots = '0;
		item_total = '0;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.action = ACT_INSERT;
		req_ch.value = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (i = 0; i < DIRECTED_ROWS; i++)
			put_request(directed[i].act, directed[i].value, directed[i].typed, directed[i].want);

		// hold off the result side while requests keep coming, so the input stalls
		refresh_pool();
		hold_left = HOLD_OFF_CYCLES;
		run_mix(60);

		send_idle_pct = 61;
		fill_and_churn();

		send_idle_pct = 0;
		stall_pct = 61;
		refresh_pool();
		run_mix(70);

		send_idle_pct = 30;
		stall_pct = 30;
		refresh_pool();
		run_mix(100);

		req_ch.valid <= 1'b0;
		stall_pct = 0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (2 * CAPACITY) @(posedge clk);

		if (mismatch_count == 0 && awaited_replies.size() == 0)
			$display("counting_multiset_table test passed");
		else
			$display("counting_multiset_table test failed");
		$finish;
	end

endmodule
